FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files.
// Bodies are empty when SYNTHESIS is defined; clk_i and rst_ni are the sampled clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CHK(lbl, !(cond), msg)

`else

`define ASSERT_CHK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: sv/otbl_pkg.sv
// Package for the ordering table bucket linker: store geometry, operation codes,
// sequencer states and table reset helpers. No dependencies.
package otbl_pkg;

  localparam int STORE_BYTES = 4096;  // power of two, 128 .. 65536
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int WP_W        = ADDR_W + 1;
  localparam int TABLE_BYTES = 64;
  localparam int NUM_BUCKETS = 16;

  typedef enum logic [2:0] {
    OP_RESET = 3'd0,
    OP_LINK  = 3'd1,
    OP_PUT   = 3'd2,
    OP_NEXT  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LK_HI,
    ST_LK_CAP,
    ST_LK_W0,
    ST_LK_W1,
    ST_LK_W2,
    ST_LK_W3,
    ST_LK_W4,
    ST_LK_W5,
    ST_NX_HD_HI,
    ST_NX_HD_CAP,
    ST_NX_CHECK,
    ST_NX_LK_HI,
    ST_NX_LK_CAP,
    ST_RD_DATA,
    ST_EMIT
  } state_e;

  // Byte address inside the bucket table.
  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [5:0] a);
    logic [ADDR_W+5:0] ext;
    ext = {{ADDR_W{1'b0}}, a};
    return ext[ADDR_W-1:0];
  endfunction

  // Reset content of a table byte: head 0, tail low byte 4b, tail high byte 0.
  function automatic logic [7:0] table_reset_byte(input logic [5:0] a);
    logic [7:0] v;
    v = '0;
    if (a[1:0] == 2'd2) begin
      v = {2'b00, a[5:2], 2'b00};
    end
    return v;
  endfunction

  // Write pointer as a 16-bit link value.
  function automatic logic [15:0] to_link16(input logic [WP_W-1:0] wp);
    logic [WP_W+15:0] ext;
    ext = {16'd0, wp};
    return ext[15:0];
  endfunction

endpackage

FILE: sv/otbl_ram.sv
// Generic single-port RAM, one access per cycle, registered read data.
// No dependencies.
module otbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ordering_table_bucket_linker.sv
// Operations use the single byte port of the store and are taken one at a time: in_stall_o
// stays high until the result is in the output register. A link reads the bucket tail,
// writes the new position into the old tail entry and the bucket tail, then zeroes the new
// entry's link bytes. A next walks the bucket heads and entry links, skipping empty buckets.
// rst_ni clears the control state; the 64-byte bucket table reads as empty through
// per-byte valid bits, so no clearing pass is needed. The reset operation does the same.
// Depends on otbl_pkg, otbl_ram and assert_macros.svh.
`include "assert_macros.svh"

module ordering_table_bucket_linker
  import otbl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [31:0] sort_key_i,
  input  logic [7:0]  data_byte_i,
  input  logic [11:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [11:0] entry_offset_o,
  output logic        entry_valid_o,
  output logic        walk_done_o,
  output logic        overflow_o
);

  state_e state_q, state_d;
  logic [WP_W-1:0]        wp_q, wp_d;
  logic [4:0]             wb_q, wb_d;
  logic [15:0]            wl_q, wl_d;
  logic                   ws_q, ws_d;
  logic [TABLE_BYTES-1:0] tvalid_q, tvalid_d;
  logic                   out_valid_q, out_valid_d;
  logic                   rd_sub_q, rd_sub_d;

  logic [3:0]  bsel_q, bsel_d;
  logic [7:0]  lo_q, lo_d;
  logic [15:0] tail_q, tail_d;
  logic [7:0]  rd_rst_q;
  logic [7:0]  res_rdata_q, res_rdata_d;
  logic [11:0] res_eoff_q, res_eoff_d;
  logic        res_ev_q, res_ev_d, res_done_q, res_done_d, res_ovf_q, res_ovf_d;
  logic [7:0]  out_rdata_q, out_rdata_d;
  logic [11:0] out_eoff_q, out_eoff_d;
  logic        out_ev_q, out_ev_d, out_done_q, out_done_d, out_ovf_q, out_ovf_d;
  logic        out_free;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata, mem_rdata, rd_fix;
  logic              mem_in_tbl;

  logic [WP_W:0]        wp_p2;
  logic                 link_ovf, put_ovf, raddr_ok;
  logic [WP_W-1:0]      wp_p1;
  logic [15:0]          pos16, tail_p1, wl_p1, wl_p2;
  logic [3:0]           nb4;
  logic [16:0]          raddr_cmp;
  logic [ADDR_W+11:0]   raddr_ext;

  otbl_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign rd_fix    = rd_sub_q ? rd_rst_q : mem_rdata;
  assign wp_p2     = {1'b0, wp_q} + (WP_W+1)'(2);
  assign link_ovf  = wp_p2 > (WP_W+1)'(STORE_BYTES);
  assign put_ovf   = wp_q >= WP_W'(STORE_BYTES);
  assign wp_p1     = wp_q + WP_W'(1);
  assign pos16     = to_link16(wp_q);
  assign tail_p1   = tail_q + 16'd1;
  assign wl_p1     = wl_q + 16'd1;
  assign wl_p2     = wl_q + 16'd2;
  assign nb4       = wb_q[3:0] + 4'd1;
  assign raddr_cmp = {5'd0, read_address_i};
  assign raddr_ok  = raddr_cmp < 17'(STORE_BYTES);
  assign raddr_ext = {{ADDR_W{1'b0}}, read_address_i};
  assign mem_in_tbl = mem_addr < ADDR_W'(TABLE_BYTES);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    wb_d        = wb_q;
    wl_d        = wl_q;
    ws_d        = ws_q;
    tvalid_d    = tvalid_q;
    bsel_d      = bsel_q;
    lo_d        = lo_q;
    tail_d      = tail_q;
    res_rdata_d = res_rdata_q;
    res_eoff_d  = res_eoff_q;
    res_ev_d    = res_ev_q;
    res_done_d  = res_done_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rdata_d = out_rdata_q;
    out_eoff_d  = out_eoff_q;
    out_ev_d    = out_ev_q;
    out_done_d  = out_done_q;
    out_ovf_d   = out_ovf_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_rdata_d = '0;
          res_eoff_d  = '0;
          res_ev_d    = 1'b0;
          res_done_d  = 1'b0;
          res_ovf_d   = 1'b0;
          bsel_d      = sort_key_i[27:24];
          state_d     = ST_EMIT;
          unique case (operation_i)
            OP_RESET: begin
              tvalid_d = '0;
              wp_d     = WP_W'(TABLE_BYTES);
              wb_d     = '0;
              wl_d     = '0;
              ws_d     = 1'b0;
            end
            OP_LINK: begin
              if (link_ovf) begin
                res_ovf_d = 1'b1;
              end else begin
                mem_re   = 1'b1;
                mem_addr = tbl_addr({sort_key_i[27:24], 2'd2});
                state_d  = ST_LK_HI;
              end
            end
            OP_PUT: begin
              if (put_ovf) begin
                res_ovf_d = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = wp_q[ADDR_W-1:0];
                mem_wdata = data_byte_i;
                wp_d      = wp_p1;
              end
            end
            OP_NEXT: begin
              if (!ws_q) begin
                ws_d     = 1'b1;
                wb_d     = '0;
                mem_re   = 1'b1;
                mem_addr = tbl_addr(6'd0);
                state_d  = ST_NX_HD_HI;
              end else begin
                state_d = ST_NX_CHECK;
              end
            end
            OP_READ: begin
              if (raddr_ok) begin
                mem_re   = 1'b1;
                mem_addr = raddr_ext[ADDR_W-1:0];
                state_d  = ST_RD_DATA;
              end
            end
            default: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end
      ST_LK_HI: begin
        mem_re   = 1'b1;
        mem_addr = tbl_addr({bsel_q, 2'd3});
        lo_d     = rd_fix;
        state_d  = ST_LK_CAP;
      end
      ST_LK_CAP: begin
        tail_d  = {rd_fix, lo_q};
        state_d = ST_LK_W0;
      end
      ST_LK_W0: begin
        mem_we    = 1'b1;
        mem_addr  = tail_q[ADDR_W-1:0];
        mem_wdata = pos16[7:0];
        state_d   = ST_LK_W1;
      end
      ST_LK_W1: begin
        mem_we    = 1'b1;
        mem_addr  = tail_p1[ADDR_W-1:0];
        mem_wdata = pos16[15:8];
        state_d   = ST_LK_W2;
      end
      ST_LK_W2: begin
        mem_we    = 1'b1;
        mem_addr  = tbl_addr({bsel_q, 2'd2});
        mem_wdata = pos16[7:0];
        state_d   = ST_LK_W3;
      end
      ST_LK_W3: begin
        mem_we    = 1'b1;
        mem_addr  = tbl_addr({bsel_q, 2'd3});
        mem_wdata = pos16[15:8];
        state_d   = ST_LK_W4;
      end
      ST_LK_W4: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q[ADDR_W-1:0];
        mem_wdata = '0;
        state_d   = ST_LK_W5;
      end
      ST_LK_W5: begin
        mem_we    = 1'b1;
        mem_addr  = wp_p1[ADDR_W-1:0];
        mem_wdata = '0;
        wp_d      = wp_p2[WP_W-1:0];
        state_d   = ST_EMIT;
      end
      ST_NX_HD_HI: begin
        mem_re   = 1'b1;
        mem_addr = tbl_addr({wb_q[3:0], 2'd1});
        lo_d     = rd_fix;
        state_d  = ST_NX_HD_CAP;
      end
      ST_NX_HD_CAP: begin
        wl_d    = {rd_fix, lo_q};
        state_d = ST_NX_CHECK;
      end
      ST_NX_CHECK: begin
        priority if (wb_q[4]) begin
          res_done_d = 1'b1;
          wl_d       = '0;
          state_d    = ST_EMIT;
        end else if (wl_q == 16'd0) begin
          wb_d = wb_q + 5'd1;
          if (wb_q[3:0] == 4'hF) begin
            state_d = ST_NX_CHECK;
          end else begin
            mem_re   = 1'b1;
            mem_addr = tbl_addr({nb4, 2'd0});
            state_d  = ST_NX_HD_HI;
          end
        end else begin
          res_eoff_d = wl_p2[11:0];
          res_ev_d   = 1'b1;
          mem_re     = 1'b1;
          mem_addr   = wl_q[ADDR_W-1:0];
          state_d    = ST_NX_LK_HI;
        end
      end
      ST_NX_LK_HI: begin
        mem_re   = 1'b1;
        mem_addr = wl_p1[ADDR_W-1:0];
        lo_d     = rd_fix;
        state_d  = ST_NX_LK_CAP;
      end
      ST_NX_LK_CAP: begin
        wl_d    = {rd_fix, lo_q};
        state_d = ST_EMIT;
      end
      ST_RD_DATA: begin
        res_rdata_d = rd_fix;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rdata_d = res_rdata_q;
          out_eoff_d  = res_eoff_q;
          out_ev_d    = res_ev_q;
          out_done_d  = res_done_q;
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (mem_we && mem_in_tbl) begin
      tvalid_d[mem_addr[5:0]] = 1'b1;
    end
  end

  assign rd_sub_d = mem_re && mem_in_tbl && !tvalid_q[mem_addr[5:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= WP_W'(TABLE_BYTES);
      wb_q        <= '0;
      wl_q        <= '0;
      ws_q        <= 1'b0;
      tvalid_q    <= '0;
      out_valid_q <= 1'b0;
      rd_sub_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      wb_q        <= wb_d;
      wl_q        <= wl_d;
      ws_q        <= ws_d;
      tvalid_q    <= tvalid_d;
      out_valid_q <= out_valid_d;
      rd_sub_q    <= rd_sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsel_q      <= bsel_d;
    lo_q        <= lo_d;
    tail_q      <= tail_d;
    rd_rst_q    <= table_reset_byte(mem_addr[5:0]);
    res_rdata_q <= res_rdata_d;
    res_eoff_q  <= res_eoff_d;
    res_ev_q    <= res_ev_d;
    res_done_q  <= res_done_d;
    res_ovf_q   <= res_ovf_d;
    out_rdata_q <= out_rdata_d;
    out_eoff_q  <= out_eoff_d;
    out_ev_q    <= out_ev_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rdata_q;
  assign entry_offset_o = out_eoff_q;
  assign entry_valid_o  = out_ev_q;
  assign walk_done_o    = out_done_q;
  assign overflow_o     = out_ovf_q;

  `ASSERT_NEVER(a_wp_bound, wp_q > WP_W'(STORE_BYTES), "write pointer beyond store")
  `ASSERT_NEVER(a_walk_bound, wb_q > 5'(NUM_BUCKETS), "walk bucket beyond table")
  `ASSERT_NEVER(a_entry_done, out_valid_q && out_ev_q && out_done_q, "entry with walk end")
  `ASSERT_CHK(a_emit_load, state_q == ST_EMIT && out_free |=> !in_stall_o, "result not loaded")

endmodule
